// ----- rtl/core/pss_pkg.sv -----
package pss_pkg;

  // Default sizes and fixed field widths
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int QUEUE_DEPTH      = 4;
  localparam int VALUE_W          = 24;
  localparam int NUM_W            = 16;
  localparam int TOTAL_W          = 32;
  localparam int CMD_W            = 3;
  localparam int FAULT_KINDS      = 3;

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_SAMPLE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ_FAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNDERFLOW = 3'd2;
  localparam logic [CMD_W-1:0] CMD_OVERFLOW  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLOSE     = 3'd4;

  // Fault counter slots
  localparam logic [1:0] FAULT_READ  = 2'd0;
  localparam logic [1:0] FAULT_UNDER = 2'd1;
  localparam logic [1:0] FAULT_OVER  = 2'd2;

  typedef enum logic [2:0] {
    KIND_SAMPLE,
    KIND_READ_FAIL,
    KIND_UNDERFLOW,
    KIND_OVERFLOW,
    KIND_CLOSE
  } kind_t;

  typedef enum logic [2:0] {
    CL_IDLE,
    CL_DIVIDE,
    CL_MUL_N,
    CL_MUL_A,
    CL_SQRT_LOAD,
    CL_MUL_T,
    CL_MUL_M,
    CL_DONE
  } close_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      sample_invalid;
  } in_item_t;

  typedef struct packed {
    logic [NUM_W-1:0]          sample_tally;
    logic [NUM_W-1:0]          valid_tally;
    logic signed [VALUE_W-1:0] min_value;
    logic signed [VALUE_W-1:0] max_value;
    logic signed [VALUE_W-1:0] mean_value;
    logic [VALUE_W-1:0]        stdev_value;
    logic [NUM_W-1:0]          per_read_errs;
    logic [NUM_W-1:0]          per_under_cnt;
    logic [NUM_W-1:0]          per_over_cnt;
    logic [TOTAL_W-1:0]        all_read_errs;
    logic [TOTAL_W-1:0]        all_under_cnt;
    logic [TOTAL_W-1:0]        all_over_cnt;
  } out_item_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [VALUE_W-1:0] value;
    logic                      invalid;
  } queue_item_t;

  // Handshake between accumulator and close engine
  typedef struct packed {
    logic start;
    logic busy;
  } close_ctrl_t;

endpackage

// ----- rtl/core/period_sample_statistics_unit.sv -----
// Throughput: one event beat (sample or fault) per cycle through the queue and accumulator;
// a beat is stored in the queue and updates the period state registers when popped. A close
// with valid samples runs a radix-2 divide, and with two or more the n*S2 and S1^2 shift-add
// multiplies, then a SAMPLE_WIDTH-step root search of two shift-add multiplies each; while it
// runs, later beats flow until the next close is at the queue head and waits. Reset clears
// the queue, all period statistics and the total fault counters.
module period_sample_statistics_unit import pss_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = COUNT_WIDTH;

  logic                              q_valid;
  queue_item_t                       q_item;
  logic                              q_pop;
  close_ctrl_t                       acc_ctrl;
  close_ctrl_t                       cl_ctrl;
  logic [CW-1:0]                     sample_count;
  logic [CW-1:0]                     valid_count;
  logic signed [SW+CW-1:0]           running_sum;
  logic [2*SW+CW-3:0]                running_square_sum;
  logic signed [SW-1:0]              running_min;
  logic signed [SW-1:0]              running_max;
  logic [FAULT_KINDS-1:0][CW-1:0]    period_faults;
  logic [FAULT_KINDS-1:0][TOTAL_W-1:0] total_faults;

  pss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pss_accum #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_accum (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .ctrl_out           (acc_ctrl),
    .ctrl_in            (cl_ctrl),
    .sample_count       (sample_count),
    .valid_count        (valid_count),
    .running_sum        (running_sum),
    .running_square_sum (running_square_sum),
    .running_min        (running_min),
    .running_max        (running_max),
    .period_faults      (period_faults),
    .total_faults       (total_faults)
  );

  pss_close #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_close (
    .clk          (clk),
    .rst          (rst),
    .ctrl_in      (acc_ctrl),
    .ctrl_out     (cl_ctrl),
    .snap_samples (sample_count),
    .snap_valid   (valid_count),
    .snap_sum     (running_sum),
    .snap_sq      (running_square_sum),
    .snap_min     (running_min),
    .snap_max     (running_max),
    .snap_period  (period_faults),
    .snap_total   (total_faults),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

  // A close is never handed over while the engine still holds the previous one
  a_close_when_free: assert property (@(posedge clk) disable iff (rst)
    acc_ctrl.start |-> !cl_ctrl.busy)
    else $error("close started while engine busy");

  // Valid samples never outnumber all samples in the period
  a_valid_le_total: assert property (@(posedge clk) disable iff (rst)
    valid_count <= sample_count)
    else $error("valid count above sample count");

  // A reported result never claims more valid samples than samples
  a_result_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.valid_tally <= out_data.sample_tally))
    else $error("result valid count above sample count");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result after reset");

endmodule

// ----- rtl/core/pss_front.sv -----
module pss_front import pss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        q_valid,
  output queue_item_t q_item,
  input  logic        q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_item_t      mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             accept;
  logic             keep;
  logic             push;
  queue_item_t      item;

  // Decode the command; unused codes are dropped
  always_comb begin
    keep         = 1'b1;
    item.value   = in_data.sample_value;
    item.invalid = in_data.sample_invalid;
    case (in_data.cmd)
      CMD_SAMPLE:    item.kind = KIND_SAMPLE;
      CMD_READ_FAIL: item.kind = KIND_READ_FAIL;
      CMD_UNDERFLOW: item.kind = KIND_UNDERFLOW;
      CMD_OVERFLOW:  item.kind = KIND_OVERFLOW;
      CMD_CLOSE:     item.kind = KIND_CLOSE;
      default: begin
        item.kind = KIND_SAMPLE;
        keep      = 1'b0;
      end
    endcase
  end

  assign in_stall = (count == CNT_W'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign push     = accept && keep;
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];

  // Store the beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/pss_accum.sv -----
module pss_accum import pss_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      q_valid,
  input  queue_item_t                               q_item,
  output logic                                      q_pop,
  output close_ctrl_t                               ctrl_out,
  input  close_ctrl_t                               ctrl_in,
  output logic [COUNT_WIDTH-1:0]                    sample_count,
  output logic [COUNT_WIDTH-1:0]                    valid_count,
  output logic signed [SAMPLE_WIDTH+COUNT_WIDTH-1:0] running_sum,
  output logic [2*SAMPLE_WIDTH+COUNT_WIDTH-3:0]     running_square_sum,
  output logic signed [SAMPLE_WIDTH-1:0]            running_min,
  output logic signed [SAMPLE_WIDTH-1:0]            running_max,
  output logic [FAULT_KINDS-1:0][COUNT_WIDTH-1:0]   period_faults,
  output logic [FAULT_KINDS-1:0][TOTAL_W-1:0]       total_faults
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CW   = COUNT_WIDTH;
  localparam int SUMW = SW + CW;
  localparam int SQW  = 2 * SW + CW - 2;
  localparam logic signed [SW-1:0] MOST_POS = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] MOST_NEG = {1'b1, {(SW-1){1'b0}}};

  logic signed [SW-1:0]   v;
  logic signed [2*SW-1:0] square;
  logic                   is_close;
  logic                   take_valid;
  logic                   fault_hit;
  logic [1:0]             fault_idx;

  assign v          = q_item.value[SW-1:0];
  assign square     = v * v;
  assign is_close   = (q_item.kind == KIND_CLOSE);
  assign q_pop      = q_valid && (!is_close || !ctrl_in.busy);
  assign take_valid = !q_item.invalid && (valid_count != '1);

  assign ctrl_out.start = q_pop && is_close;
  assign ctrl_out.busy  = 1'b0;

  // Map the fault kind to its counter slot
  always_comb begin
    fault_hit = 1'b1;
    case (q_item.kind)
      KIND_READ_FAIL: fault_idx = FAULT_READ;
      KIND_UNDERFLOW: fault_idx = FAULT_UNDER;
      KIND_OVERFLOW:  fault_idx = FAULT_OVER;
      default: begin
        fault_idx = FAULT_READ;
        fault_hit = 1'b0;
      end
    endcase
  end

  // Accumulate one beat; clear the period on close
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count       <= '0;
      valid_count        <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      running_min        <= MOST_POS;
      running_max        <= MOST_NEG;
      period_faults      <= '0;
      total_faults       <= '0;
    end else if (q_pop) begin
      if (is_close) begin
        sample_count       <= '0;
        valid_count        <= '0;
        running_sum        <= '0;
        running_square_sum <= '0;
        running_min        <= MOST_POS;
        running_max        <= MOST_NEG;
        period_faults      <= '0;
      end else if (q_item.kind == KIND_SAMPLE) begin
        if (sample_count != '1) begin
          sample_count <= sample_count + 1'b1;
        end
        if (take_valid) begin
          valid_count        <= valid_count + 1'b1;
          running_sum        <= running_sum + SUMW'(v);
          running_square_sum <= running_square_sum + SQW'($unsigned(square));
          if (v < running_min) begin
            running_min <= v;
          end
          if (v > running_max) begin
            running_max <= v;
          end
        end
      end else if (fault_hit) begin
        if (period_faults[fault_idx] != '1) begin
          period_faults[fault_idx] <= period_faults[fault_idx] + 1'b1;
        end
        if (total_faults[fault_idx] != '1) begin
          total_faults[fault_idx] <= total_faults[fault_idx] + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/pss_close.sv -----
module pss_close import pss_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  close_ctrl_t                                ctrl_in,
  output close_ctrl_t                                ctrl_out,
  input  logic [COUNT_WIDTH-1:0]                     snap_samples,
  input  logic [COUNT_WIDTH-1:0]                     snap_valid,
  input  logic signed [SAMPLE_WIDTH+COUNT_WIDTH-1:0] snap_sum,
  input  logic [2*SAMPLE_WIDTH+COUNT_WIDTH-3:0]      snap_sq,
  input  logic signed [SAMPLE_WIDTH-1:0]             snap_min,
  input  logic signed [SAMPLE_WIDTH-1:0]             snap_max,
  input  logic [FAULT_KINDS-1:0][COUNT_WIDTH-1:0]    snap_period,
  input  logic [FAULT_KINDS-1:0][TOTAL_W-1:0]        snap_total,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output out_item_t                                  out_data
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CW   = COUNT_WIDTH;
  localparam int SUMW = SW + CW;
  localparam int SQW  = 2 * SW + CW - 2;
  localparam int AW   = SW + CW - 1;
  localparam int DIVW = SW + CW + 1;
  localparam int DCW  = $clog2(DIVW);
  localparam int PW   = 2 * SW + 2 * CW + 2;
  localparam int BW   = $clog2(SW);

  close_state_t       state;
  close_state_t       state_next;
  logic [CW-1:0]      n;
  logic               neg;
  logic [AW-1:0]      a_abs;
  logic [SQW-1:0]     sq;
  logic [2*CW-1:0]    m;
  logic [DIVW-1:0]    dq;
  logic [CW:0]        rem;
  logic [DCW-1:0]     div_cnt;
  logic [PW-1:0]      dval;
  logic [PW-1:0]      acc;
  logic [PW-1:0]      x;
  logic [PW-1:0]      y;
  logic [SW-1:0]      r;
  logic [BW-1:0]      b;
  out_item_t          res;

  logic [SUMW-1:0]    sum_mag;
  logic [CW+1:0]      trial;
  logic [CW+1:0]      div2n;
  logic               ge;
  logic [DIVW-1:0]    q_final;
  logic signed [SW:0] q_signed;
  logic signed [SW:0] mean_val;
  logic [PW-1:0]      acc_step;
  logic               y_done;
  logic               div_last;
  logic [SW-1:0]      c_cur;
  logic [SW:0]        t;
  logic [SW-1:0]      r_new;

  assign sum_mag  = snap_sum[SUMW-1] ? SUMW'(-snap_sum) : SUMW'(snap_sum);
  assign trial    = {rem, dq[DIVW-1]};
  assign div2n    = {1'b0, n, 1'b0};
  assign ge       = (trial >= div2n);
  assign q_final  = {dq[DIVW-2:0], ge};
  assign q_signed = signed'((SW+1)'(q_final));
  assign mean_val = neg ? -q_signed : q_signed;
  assign acc_step = y[0] ? acc + x : acc;
  assign y_done   = (y == '0);
  assign div_last = (div_cnt == DCW'(DIVW - 1));
  assign c_cur    = r | (SW'(1) << b);
  assign t        = {c_cur, 1'b0} - (SW+1)'(1);
  assign r_new    = (acc <= dval) ? c_cur : r;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      CL_IDLE: begin
        if (ctrl_in.start) begin
          state_next = (snap_valid == '0) ? CL_DONE : CL_DIVIDE;
        end
      end
      CL_DIVIDE: begin
        if (div_last) begin
          state_next = (n == CW'(1)) ? CL_DONE : CL_MUL_N;
        end
      end
      CL_MUL_N: begin
        if (y_done) begin
          state_next = CL_MUL_A;
        end
      end
      CL_MUL_A: begin
        if (y_done) begin
          state_next = CL_SQRT_LOAD;
        end
      end
      CL_SQRT_LOAD: state_next = CL_MUL_T;
      CL_MUL_T: begin
        if (y_done) begin
          state_next = CL_MUL_M;
        end
      end
      CL_MUL_M: begin
        if (y_done) begin
          state_next = (b == '0) ? CL_DONE : CL_SQRT_LOAD;
        end
      end
      CL_DONE: begin
        if (!out_stall) begin
          state_next = CL_IDLE;
        end
      end
      default: state_next = CL_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    out_valid      = (state == CL_DONE);
    ctrl_out.busy  = (state != CL_IDLE);
    ctrl_out.start = 1'b0;
  end

  assign out_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: divide for the mean, then D = n*S2 - S1^2 and a bitwise root search
  always_ff @(posedge clk) begin
    case (state)
      CL_IDLE: begin
        if (ctrl_in.start) begin
          n       <= snap_valid;
          neg     <= snap_sum[SUMW-1];
          a_abs   <= AW'(sum_mag);
          sq      <= snap_sq;
          m       <= (2*CW)'(snap_valid) * (2*CW)'(snap_valid - 1'b1);
          dq      <= DIVW'({sum_mag, 1'b0}) + DIVW'(snap_valid);
          rem     <= '0;
          div_cnt <= '0;
          r       <= '0;
          b       <= BW'(SW - 1);
          res.sample_tally  <= NUM_W'(snap_samples);
          res.valid_tally   <= NUM_W'(snap_valid);
          res.min_value     <= (snap_valid == '0) ? '0 : VALUE_W'(snap_min);
          res.max_value     <= (snap_valid == '0) ? '0 : VALUE_W'(snap_max);
          res.mean_value    <= '0;
          res.stdev_value   <= '0;
          res.per_read_errs <= NUM_W'(snap_period[FAULT_READ]);
          res.per_under_cnt <= NUM_W'(snap_period[FAULT_UNDER]);
          res.per_over_cnt  <= NUM_W'(snap_period[FAULT_OVER]);
          res.all_read_errs <= snap_total[FAULT_READ];
          res.all_under_cnt <= snap_total[FAULT_UNDER];
          res.all_over_cnt  <= snap_total[FAULT_OVER];
        end
      end
      CL_DIVIDE: begin
        rem     <= ge ? (CW+1)'(trial - div2n) : (CW+1)'(trial);
        dq      <= q_final;
        div_cnt <= div_cnt + 1'b1;
        if (div_last) begin
          res.mean_value <= VALUE_W'(mean_val);
          acc            <= '0;
          x              <= PW'(sq);
          y              <= PW'(n);
        end
      end
      CL_MUL_N: begin
        if (!y_done) begin
          acc <= acc_step;
          x   <= x << 1;
          y   <= y >> 1;
        end else begin
          dval <= acc;
          acc  <= '0;
          x    <= PW'(a_abs);
          y    <= PW'(a_abs);
        end
      end
      CL_MUL_A: begin
        if (!y_done) begin
          acc <= acc_step;
          x   <= x << 1;
          y   <= y >> 1;
        end else begin
          dval <= (dval - acc) << 2;
        end
      end
      CL_SQRT_LOAD: begin
        acc <= '0;
        x   <= PW'(t);
        y   <= PW'(t);
      end
      CL_MUL_T: begin
        if (!y_done) begin
          acc <= acc_step;
          x   <= x << 1;
          y   <= y >> 1;
        end else begin
          acc <= '0;
          x   <= acc;
          y   <= PW'(m);
        end
      end
      CL_MUL_M: begin
        if (!y_done) begin
          acc <= acc_step;
          x   <= x << 1;
          y   <= y >> 1;
        end else begin
          r <= r_new;
          if (b == '0) begin
            res.stdev_value <= VALUE_W'(r_new);
          end else begin
            b <= b - 1'b1;
          end
        end
      end
      CL_DONE: begin
        res <= res;
      end
      default: begin
        res <= res;
      end
    endcase
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import pss_pkg::*;

  // Codes 5 to 7 have no meaning and are dropped by the block
  localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;
  localparam int IDLE_LIMIT = 20000;
  localparam int ITEMS_PER_PHASE = 600;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 24'sh800000;

  // Expected close reports and the period/total statistics behind them
  class stats_scoreboard;
    int unsigned smp_cnt;
    int unsigned val_cnt;
    longint sum;
    logic [63:0] sq_sum;
    longint lo_val;
    longint hi_val;
    int unsigned per_fault[FAULT_KINDS];
    longint unsigned tot_fault[FAULT_KINDS];
    out_item_t reports[$];
    int errors;

    function new();
      clear_period();
      foreach (tot_fault[k]) tot_fault[k] = 0;
      errors = 0;
    endfunction

    function void clear_period();
      smp_cnt = 0;
      val_cnt = 0;
      sum = 0;
      sq_sum = 0;
      lo_val = VAL_MAX;
      hi_val = VAL_MIN;
      foreach (per_fault[k]) per_fault[k] = 0;
    endfunction

    // Exact round(sqrt((n*S2 - S1^2) / (n*(n-1)))) by bitwise search
    function logic [VALUE_W-1:0] deviation(longint unsigned n);
      logic [127:0] diff4;
      logic [127:0] prod;
      longint unsigned mag;
      longint unsigned m;
      longint unsigned c;
      longint unsigned t;
      longint unsigned r;
      mag = sum < 0 ? longint'(-sum) : longint'(sum);
      diff4 = (128'(n) * 128'(sq_sum) - 128'(mag) * 128'(mag)) << 2;
      m = n * (n - 1);
      r = 0;
      for (int b = VALUE_W - 1; b >= 0; b--) begin
        c = r | (64'd1 << b);
        t = 2 * c - 1;
        prod = 128'(t * t) * 128'(m);
        if (prod <= diff4) r = c;
      end
      return r[VALUE_W-1:0];
    endfunction

    function out_item_t close_report();
      out_item_t rep;
      longint unsigned n;
      longint unsigned mag;
      longint unsigned q;
      rep = '0;
      n = val_cnt;
      rep.sample_tally = smp_cnt[NUM_W-1:0];
      rep.valid_tally = val_cnt[NUM_W-1:0];
      if (n != 0) begin
        mag = sum < 0 ? longint'(-sum) : longint'(sum);
        q = (2 * mag + n) / (2 * n);
        rep.min_value = lo_val[VALUE_W-1:0];
        rep.max_value = hi_val[VALUE_W-1:0];
        rep.mean_value = sum < 0 ? VALUE_W'(-longint'(q)) : VALUE_W'(q);
        if (n > 1) rep.stdev_value = deviation(n);
      end
      rep.per_read_errs = per_fault[FAULT_READ][NUM_W-1:0];
      rep.per_under_cnt = per_fault[FAULT_UNDER][NUM_W-1:0];
      rep.per_over_cnt = per_fault[FAULT_OVER][NUM_W-1:0];
      rep.all_read_errs = tot_fault[FAULT_READ][TOTAL_W-1:0];
      rep.all_under_cnt = tot_fault[FAULT_UNDER][TOTAL_W-1:0];
      rep.all_over_cnt = tot_fault[FAULT_OVER][TOTAL_W-1:0];
      return rep;
    endfunction

    // Advance the period state by one accepted input beat
    function void note_input(in_item_t it);
      longint v;
      int k;
      v = longint'(it.sample_value);
      case (it.cmd)
        CMD_SAMPLE: begin
          if (smp_cnt < 65535) smp_cnt++;
          if (!it.sample_invalid && val_cnt < 65535) begin
            val_cnt++;
            sum += v;
            sq_sum += 64'(v * v);
            if (v < lo_val) lo_val = v;
            if (v > hi_val) hi_val = v;
          end
        end
        CMD_READ_FAIL, CMD_UNDERFLOW, CMD_OVERFLOW: begin
          k = int'(it.cmd - CMD_READ_FAIL);
          if (per_fault[k] < 65535) per_fault[k]++;
          if (tot_fault[k] < 64'hFFFF_FFFF) tot_fault[k]++;
        end
        CMD_CLOSE: begin
          reports.insert(reports.size(), close_report());
          clear_period();
        end
        default: ;
      endcase
    endfunction

    function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %h, got %h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (reports.size() == 0) begin
        $error("unexpected close report %p", got);
        errors++;
        return;
      end
      e = reports.pop_front();
      cmp_field("sample_tally", e.sample_tally, got.sample_tally);
      cmp_field("valid_tally", e.valid_tally, got.valid_tally);
      cmp_field("min_value", e.min_value, got.min_value);
      cmp_field("max_value", e.max_value, got.max_value);
      cmp_field("mean_value", e.mean_value, got.mean_value);
      cmp_field("stdev_value", e.stdev_value, got.stdev_value);
      cmp_field("per_read_errs", e.per_read_errs, got.per_read_errs);
      cmp_field("per_under_cnt", e.per_under_cnt, got.per_under_cnt);
      cmp_field("per_over_cnt", e.per_over_cnt, got.per_over_cnt);
      cmp_field("all_read_errs", e.all_read_errs, got.all_read_errs);
      cmp_field("all_under_cnt", e.all_under_cnt, got.all_under_cnt);
      cmp_field("all_over_cnt", e.all_over_cnt, got.all_over_cnt);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  stats_scoreboard stats = new();
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;
  int phase_items;

  period_sample_statistics_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Drive receiver stall, check report beats, watch for a hang
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (!rst && out_valid && !out_stall) begin
      stats.check_result(out_data);
      quiet_cycles <= 0;
    end else if (!rst && in_valid && !in_stall) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    stats.note_input(it);
    phase_items++;
  endtask

  task automatic send_cmd(logic [CMD_W-1:0] cmd);
    in_item_t it;
    it = '0;
    it.cmd = cmd;
    it.sample_value = 24'($urandom);
    it.sample_invalid = 1'($urandom_range(1));
    send_beat(it);
  endtask

  task automatic send_sample(logic signed [VALUE_W-1:0] v, logic nan);
    in_item_t it;
    it.cmd = CMD_SAMPLE;
    it.sample_value = v;
    it.sample_invalid = nan;
    send_beat(it);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(2047)) - 1024);
      2: return $urandom_range(1) ? VAL_MAX : VAL_MIN;
      default: return 24'($signed(16'($urandom)));
    endcase
  endfunction

  // One period: random events, mostly valid samples, then a close
  task automatic send_period();
    int len;
    int r;
    len = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 20);
    if ($urandom_range(9) == 0) begin
      send_sample(pick_value(), 1'b0);
      len = 0;
    end
    repeat (len) begin
      r = $urandom_range(99);
      if (r < 60) send_sample(pick_value(), 1'b0);
      else if (r < 68) send_sample(pick_value(), 1'b1);
      else if (r < 76) send_cmd(CMD_READ_FAIL);
      else if (r < 84) send_cmd(CMD_UNDERFLOW);
      else if (r < 92) send_cmd(CMD_OVERFLOW);
      else send_cmd(3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)));
    end
    send_cmd(CMD_CLOSE);
  endtask

  task automatic directed_part();
    // close on an empty period
    send_cmd(CMD_CLOSE);
    // single samples at both extremes
    send_sample(VAL_MAX, 1'b0);
    send_cmd(CMD_CLOSE);
    send_sample(VAL_MIN, 1'b0);
    send_cmd(CMD_CLOSE);
    // widest spread
    send_sample(VAL_MIN, 1'b0);
    send_sample(VAL_MAX, 1'b0);
    send_cmd(CMD_CLOSE);
    // only not-a-number samples
    send_sample(24'sh000100, 1'b1);
    send_sample(VAL_MIN, 1'b1);
    send_cmd(CMD_CLOSE);
    // each fault kind and the spare codes
    send_cmd(CMD_READ_FAIL);
    send_cmd(CMD_UNDERFLOW);
    send_cmd(CMD_OVERFLOW);
    send_cmd(CMD_SPARE_LO);
    send_cmd(CMD_SPARE_MID);
    send_cmd(CMD_SPARE_HI);
    send_cmd(CMD_CLOSE);
    // mean halfway cases, positive and negative
    send_sample(24'sd1, 1'b0);
    send_sample(24'sd2, 1'b0);
    send_cmd(CMD_CLOSE);
    send_sample(-24'sd1, 1'b0);
    send_sample(-24'sd2, 1'b0);
    send_cmd(CMD_CLOSE);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 32;
    recv_stall_pct = 87;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 32 : (p == 1) ? 87 : 0;
      recv_stall_pct = (p == 0) ? 87 : (p == 1) ? 32 : 0;
      phase_items = 0;
      if (p == 0) directed_part();
      while (phase_items < ITEMS_PER_PHASE) send_period();
    end
    in_valid <= 1'b0;
    while (stats.reports.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (stats.reports.size() != 0) begin
      $error("%0d close reports never arrived", stats.reports.size());
      stats.errors++;
    end
    if (stats.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
